@@ src/scanline_irq_multiplier_regs_defines.svh @@
// Assertion macros shared by the scanline IRQ register block.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef SCANLINE_IRQ_MULTIPLIER_REGS_DEFINES_SVH
`define SCANLINE_IRQ_MULTIPLIER_REGS_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SIRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SIRQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/sirq_pkg.sv @@
// Types and constants for the scanline IRQ / multiplier / extended RAM block.
// No dependencies.
`default_nettype none
package sirq_pkg;

  localparam int EXT_RAM_DEPTH = 1024;
  localparam int EXT_AW        = $clog2(EXT_RAM_DEPTH);
  localparam logic [EXT_AW-1:0] EXT_LAST = EXT_AW'(EXT_RAM_DEPTH - 1);

  typedef enum logic [2:0] {
    KIND_CPU_WR   = 3'd0,
    KIND_CPU_RD   = 3'd1,
    KIND_PPU_FET  = 3'd2,
    KIND_PPU_REG  = 3'd3,
    KIND_FRAME    = 3'd4
  } kind_t;

  localparam logic [15:0] ADDR_EXT_MODE = 16'h5104;
  localparam logic [15:0] ADDR_TARGET   = 16'h5203;
  localparam logic [15:0] ADDR_STATUS   = 16'h5204;
  localparam logic [15:0] ADDR_MUL_LO   = 16'h5205;
  localparam logic [15:0] ADDR_MUL_HI   = 16'h5206;
  localparam logic [15:0] EXT_BASE      = 16'h5c00;
  localparam logic [15:0] EXT_MASK      = 16'h03ff;
  localparam logic [7:0]  ENABLE_BIT    = 8'h80;
  localparam logic [7:0]  RENDER_BITS   = 8'h18;
  localparam logic [1:0]  EXT_MODE_RW   = 2'd2;
  localparam logic [2:0]  PPU_MASK_REG  = 3'd1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
  } out_word_t;

endpackage
`default_nettype wire

@@ src/sirq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module sirq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ src/scanline_irq_multiplier_regs.sv @@
// Scanline IRQ, 8x8 multiplier and 1 KiB extended RAM register block.
// Depends on sirq_pkg, sirq_ram and scanline_irq_multiplier_regs_defines.svh.
`default_nettype none
`include "scanline_irq_multiplier_regs_defines.svh"

// One bus event is taken per word on the input channel: CPU register write or
// read, PPU fetch address, PPU register write, or end of frame. Every event
// gives exactly one result word: the byte read (zero for non-reads) and the IRQ
// line as it stands after the event. The block takes one word every cycle
// while in_ready is high; a result passes through the read stage (the extended
// RAM's registered read) and then the output register, and stalls on the output
// side back up only once both the read stage and the output register are full.
// All scalar state (scanline counter, flags, multiplier operands, fetch history)
// lives in flops and is updated in the cycle a word is taken, so back-to-back
// fetches and status reads see each other without bubbles. The extended RAM is
// a single memory written and read in the accept cycle; a read issued the cycle
// after a write already sees the new byte. After reset, the block sweeps all
// 1024 bytes of the extended RAM to zero one byte per cycle, with in_ready
// held low until the sweep is done.
module scanline_irq_multiplier_regs (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sirq_pkg::in_word_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sirq_pkg::out_word_t     out_data
);

  // ---------------------------------------------------------------------------
  // Clearing sweep after reset
  // ---------------------------------------------------------------------------
  logic                      clearing_r, clearing_nxt;
  logic [sirq_pkg::EXT_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  always_comb begin
    clearing_nxt = clearing_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == sirq_pkg::EXT_LAST) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------------
  logic s1_v_r, s1_v_nxt;       // read stage holds a word waiting for RAM data
  logic out_v_r, out_v_nxt;     // output register holds a result
  logic s1_adv;                 // read stage may move into the output register
  logic acc;                    // input word taken this cycle

  assign s1_adv   = !out_v_r || out_ready;
  assign in_ready = !clearing_r && (!s1_v_r || s1_adv);
  assign acc      = in_valid && in_ready;

  always_comb begin
    s1_v_nxt  = s1_v_r;
    out_v_nxt = out_v_r;
    if (s1_adv) begin
      out_v_nxt = s1_v_r;
      s1_v_nxt  = 1'b0;
    end
    if (acc) begin
      s1_v_nxt = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Scalar state
  // ---------------------------------------------------------------------------
  logic [7:0]  target_r,   target_nxt;
  logic        enable_r,   enable_nxt;
  logic [7:0]  count_r,    count_nxt;
  logic        pend_r,     pend_nxt;
  logic        inframe_r,  inframe_nxt;
  logic        irq_r,      irq_nxt;
  logic [7:0]  fac_a_r,    fac_a_nxt;
  logic [7:0]  fac_b_r,    fac_b_nxt;
  logic [1:0]  mode_r,     mode_nxt;
  logic [15:0] prev0_r,    prev0_nxt;
  logic [15:0] prev1_r,    prev1_nxt;

  // Read stage payload
  logic        s1_ram_r,   s1_ram_nxt;
  logic [7:0]  s1_byte_r,  s1_byte_nxt;
  logic        s1_irq_r,   s1_irq_nxt;
  sirq_pkg::out_word_t out_word_r, out_word_nxt;

  logic [15:0] prod;
  logic        in_window;
  logic [7:0]  count_inc;
  logic        ram_we;
  logic [sirq_pkg::EXT_AW-1:0] ram_waddr;
  logic [7:0]  ram_wdata;
  logic        ram_re;
  logic [7:0]  ram_rdata;
  logic        status_rd;

  assign prod      = 16'(fac_a_r) * 16'(fac_b_r);
  assign in_window = (in_data.address & ~sirq_pkg::EXT_MASK) == sirq_pkg::EXT_BASE;
  assign count_inc = count_r + 8'd1;
  assign status_rd = acc && (in_data.kind == sirq_pkg::KIND_CPU_RD)
                     && (in_data.address == sirq_pkg::ADDR_STATUS);

  always_comb begin
    target_nxt  = target_r;
    enable_nxt  = enable_r;
    count_nxt   = count_r;
    pend_nxt    = pend_r;
    inframe_nxt = inframe_r;
    irq_nxt     = irq_r;
    fac_a_nxt   = fac_a_r;
    fac_b_nxt   = fac_b_r;
    mode_nxt    = mode_r;
    prev0_nxt   = prev0_r;
    prev1_nxt   = prev1_r;
    s1_ram_nxt  = s1_ram_r;
    s1_byte_nxt = s1_byte_r;
    s1_irq_nxt  = s1_irq_r;
    ram_we      = 1'b0;
    if (acc) begin
      s1_ram_nxt  = 1'b0;
      s1_byte_nxt = 8'd0;
      unique case (in_data.kind)
        sirq_pkg::KIND_CPU_WR: begin
          unique case (in_data.address)
            sirq_pkg::ADDR_EXT_MODE: mode_nxt   = in_data.write_data[1:0];
            sirq_pkg::ADDR_TARGET:   target_nxt = in_data.write_data;
            sirq_pkg::ADDR_STATUS:
              enable_nxt = |(in_data.write_data & sirq_pkg::ENABLE_BIT);
            sirq_pkg::ADDR_MUL_LO:   fac_a_nxt  = in_data.write_data;
            sirq_pkg::ADDR_MUL_HI:   fac_b_nxt  = in_data.write_data;
            default: ram_we = in_window && (mode_r == sirq_pkg::EXT_MODE_RW);
          endcase
        end
        sirq_pkg::KIND_CPU_RD: begin
          unique case (in_data.address)
            sirq_pkg::ADDR_STATUS: begin
              s1_byte_nxt = {pend_r, inframe_r, 6'd0};
              pend_nxt    = 1'b0;
              irq_nxt     = 1'b0;
            end
            sirq_pkg::ADDR_MUL_LO: s1_byte_nxt = prod[7:0];
            sirq_pkg::ADDR_MUL_HI: s1_byte_nxt = prod[15:8];
            default: begin
              s1_byte_nxt = in_data.address[15:8];
              s1_ram_nxt  = in_window && mode_r[1];
            end
          endcase
        end
        sirq_pkg::KIND_PPU_FET: begin
          // Three equal fetch addresses in a row clock the scanline counter.
          if (in_data.address == prev0_r && in_data.address == prev1_r) begin
            if (!inframe_r) begin
              inframe_nxt = 1'b1;
              pend_nxt    = 1'b0;
              count_nxt   = 8'd0;
            end else begin
              count_nxt = count_inc;
              if (count_inc == target_r) begin
                pend_nxt = 1'b1;
                if (enable_r) begin
                  irq_nxt = 1'b1;
                end
              end
            end
          end
          prev1_nxt = prev0_r;
          prev0_nxt = in_data.address;
        end
        sirq_pkg::KIND_PPU_REG: begin
          // Rendering turned off: drop out of frame.
          if (in_data.address[2:0] == sirq_pkg::PPU_MASK_REG
              && (in_data.write_data & sirq_pkg::RENDER_BITS) == 8'd0) begin
            inframe_nxt = 1'b0;
          end
        end
        sirq_pkg::KIND_FRAME: inframe_nxt = 1'b0;
        default: ;
      endcase
      s1_irq_nxt = irq_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Extended RAM: sweep port during clearing, bus port after
  // ---------------------------------------------------------------------------
  always_comb begin
    if (clearing_r) begin
      ram_waddr = clr_cnt_r;
      ram_wdata = 8'd0;
    end else begin
      ram_waddr = in_data.address[sirq_pkg::EXT_AW-1:0];
      ram_wdata = in_data.write_data;
    end
  end

  // Only read on accept so the data holds while the read stage is stalled.
  assign ram_re = acc;

  sirq_ram #(
    .WIDTH (8),
    .DEPTH (sirq_pkg::EXT_RAM_DEPTH)
  ) u_ext_ram (
    .clk   (clk),
    .we    (clearing_r || ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (in_data.address[sirq_pkg::EXT_AW-1:0]),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_comb begin
    out_word_nxt = out_word_r;
    if (s1_adv && s1_v_r) begin
      out_word_nxt.read_data = s1_ram_r ? ram_rdata : s1_byte_r;
      out_word_nxt.irq_line  = s1_irq_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      target_r   <= 8'd0;
      enable_r   <= 1'b0;
      count_r    <= 8'd0;
      pend_r     <= 1'b0;
      inframe_r  <= 1'b0;
      irq_r      <= 1'b0;
      fac_a_r    <= 8'd0;
      fac_b_r    <= 8'd0;
      mode_r     <= 2'd0;
      prev0_r    <= 16'hffff;
      prev1_r    <= 16'hffff;
    end else begin
      clearing_r <= clearing_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      s1_v_r     <= s1_v_nxt;
      out_v_r    <= out_v_nxt;
      target_r   <= target_nxt;
      enable_r   <= enable_nxt;
      count_r    <= count_nxt;
      pend_r     <= pend_nxt;
      inframe_r  <= inframe_nxt;
      irq_r      <= irq_nxt;
      fac_a_r    <= fac_a_nxt;
      fac_b_r    <= fac_b_nxt;
      mode_r     <= mode_nxt;
      prev0_r    <= prev0_nxt;
      prev1_r    <= prev1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_ram_r   <= s1_ram_nxt;
    s1_byte_r  <= s1_byte_nxt;
    s1_irq_r   <= s1_irq_nxt;
    out_word_r <= out_word_nxt;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SIRQ_ASSERT_ALWAYS(a_no_accept_in_clear, clearing_r |-> !in_ready,
    "word taken during RAM sweep")
  `SIRQ_ASSERT(a_clear_once, !clearing_r |=> !clearing_r,
    "RAM sweep restarted without reset")
  `SIRQ_ASSERT(a_status_clears, status_rd |=> (!pend_r && !irq_r),
    "status read left IRQ or pending set")
  `SIRQ_ASSERT(a_irq_from_fetch,
    $rose(irq_r) |-> $past(acc && in_data.kind == sirq_pkg::KIND_PPU_FET),
    "IRQ raised outside a fetch")
  `SIRQ_ASSERT(a_s1_holds, (s1_v_r && !s1_adv) |=> s1_v_r,
    "read stage dropped a word under stall")

endmodule
`default_nettype wire
